FILE: rtl/gauge_stepper_microstep_driver_unit_defines.svh
// Assertion macros shared by the gauge stepper driver RTL.
// Expect signals named clk and rst_n in the scope of each use.
`ifndef GAUGE_STEPPER_MICROSTEP_DRIVER_UNIT_DEFINES_SVH
`define GAUGE_STEPPER_MICROSTEP_DRIVER_UNIT_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define GSMD_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define GSMD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define GSMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/gsmd_pkg.sv
// Package for the gauge stepper microstep driver: widths, codes, types
// and the microstep wave lookup. No dependencies.
`timescale 1ns / 1ps

package gsmd_pkg;

  localparam int POS_W       = 15;
  localparam int LEVEL_W     = 10;
  localparam int NUM_LEVELS  = 7;
  localparam int PERIOD_W    = 16;
  localparam int RELOAD_W    = 22;
  localparam int RELOAD_SH   = 6;
  localparam int PHASE_W     = 5;
  localparam int PHASES      = 24;
  localparam int COIL_OFFSET = 6;
  localparam int DIV_W       = 23;
  localparam int DIVISOR_W   = 15;
  localparam int DIV_CNT_W   = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 64;

  localparam int HISTORY_DEPTH_DEF = 8;

  localparam logic [DIV_W-1:0]    STEP_RATE_NUM = DIV_W'(500000);
  localparam logic [PERIOD_W-1:0] PERIOD_MAX    = 16'd65535;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN    = 16'd250;
  localparam logic [PERIOD_W-1:0] PERIOD_REFILL = 16'hFFFF;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET [NUM_LEVELS] = '{
    10'd0, 10'd265, 10'd512, 10'd724, 10'd886, 10'd988, 10'd1023
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEVEL0  = 3'd0,
    REG_LEVEL1  = 3'd1,
    REG_LEVEL2  = 3'd2,
    REG_LEVEL3  = 3'd3,
    REG_LEVEL4  = 3'd4,
    REG_LEVEL5  = 3'd5,
    REG_LEVEL6  = 3'd6,
    REG_REVERSE = 3'd7
  } reg_idx_t;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BACK = 2'd2
  } dir_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic do_tick;
    logic coil_b;
    logic upd_check;
    logic div_start;
    logic div_avg;
    logic commit;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic upd_go;
    logic div_done;
  } sts_t;

  typedef struct packed {
    logic [2:0] sel;
    logic       neg;
  } wave_t;

  // Map a phase 0..23 to a level register and a coil sign.
  function automatic wave_t wave_lookup(logic [PHASE_W-1:0] ph);
    wave_t w;
    logic [PHASE_W-1:0] k;
    if (ph <= 5'd6) begin
      k = ph;
      w.neg = 1'b0;
    end else if (ph <= 5'd12) begin
      k = 5'd12 - ph;
      w.neg = 1'b0;
    end else if (ph <= 5'd18) begin
      k = ph - 5'd12;
      w.neg = 1'b1;
    end else begin
      k = 5'd24 - ph;
      w.neg = 1'b1;
    end
    w.sel = k[2:0];
    return w;
  endfunction

endpackage

FILE: rtl/gsmd_divider.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on gsmd_pkg for widths.
`timescale 1ns / 1ps

module gsmd_divider
  import gsmd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_W-1:0]     dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 done,
  output logic [DIV_W-1:0]     quotient
);

  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [DIVISOR_W-1:0] dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIVISOR_W:0]   trial;

  assign trial = {rem_r, quo_r[DIV_W-1]};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = DIV_CNT_W'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DIVISOR_W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIVISOR_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/gsmd_datapath.sv
// Datapath: level registers, position and phase state, period history,
// serial divider and the result register. Depends on gsmd_pkg, gsmd_divider.
`timescale 1ns / 1ps

`include "gauge_stepper_microstep_driver_unit_defines.svh"

module gsmd_datapath
  import gsmd_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [LEVEL_W-1:0]    cfg_wdata,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SUM_W  = PERIOD_W + $clog2(HISTORY_DEPTH + 1);
  localparam logic [SUM_W-1:0]  REFILL_SUM = SUM_W'(HISTORY_DEPTH * 65535);
  localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(HISTORY_DEPTH - 1);
  // Average by reciprocal multiply, exact for every sum below 2**SUM_W.
  localparam int AVG_SH = SUM_W + $clog2(HISTORY_DEPTH);
  localparam int PROD_W = AVG_SH + PERIOD_W;
  localparam longint AVG_MUL_L =
    ((longint'(1) << AVG_SH) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
  localparam logic [SUM_W:0] AVG_MUL = (SUM_W + 1)'(AVG_MUL_L);

  logic [LEVEL_W-1:0]    level_r [NUM_LEVELS];
  logic                  reverse_r;
  logic [POS_W-1:0]      pos_r;
  logic [POS_W-1:0]      target_r;
  dir_t                  dir_r;
  logic [PHASE_W-1:0]    phase_r;
  logic [PHASE_W-1:0]    phase_b_r;
  logic                  timer_r;
  logic                  active_r;
  logic [PERIOD_W-1:0]   hist_r [HISTORY_DEPTH];
  logic [SLOT_W-1:0]     slot_r;
  logic [SUM_W-1:0]      sum_r;
  logic [PERIOD_W-1:0]   avg_r;
  logic                  reversed_r;
  logic [POS_W-1:0]      gap_r;
  logic [POS_W-1:0]      tgt_in_r;
  logic                  req_r;
  logic                  stepped_r;
  logic [LEVEL_W-1:0]    coil_a_mag_r, coil_b_mag_r;
  logic                  coil_a_neg_r, coil_b_neg_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                  act;
  logic                  fwd_target;
  logic                  step_fwd;
  logic                  phase_up;
  logic [PHASE_W-1:0]    phase_next;
  logic [PHASE_W:0]      phase_off;
  logic [PHASE_W-1:0]    phase_b_next;
  wave_t                 wv;
  logic [LEVEL_W-1:0]    level_rd;
  logic [DIV_W-1:0]      div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic [DIV_W-1:0]      quotient;
  logic                  div_done;
  logic [PERIOD_W-1:0]   raw_period;
  logic [PERIOD_W-1:0]   hist_old;
  logic [SUM_W-1:0]      total;
  logic [PROD_W-1:0]     avg_prod;
  logic [PERIOD_W-1:0]   avg_new;
  logic                  at_target;

  assign act        = active_r | req_r;
  assign fwd_target = tgt_in_r > pos_r;
  assign at_target  = pos_r == target_r;
  assign step_fwd   = dir_r == DIR_FWD;
  assign phase_up   = step_fwd ^ reverse_r;

  always_comb begin
    if (phase_up) begin
      phase_next = (phase_r >= PHASE_W'(PHASES - 1)) ? '0 : phase_r + 1'b1;
    end else begin
      phase_next = (phase_r == '0) ? PHASE_W'(PHASES - 1) : phase_r - 1'b1;
    end
  end

  // Second coil runs a quarter wave ahead.
  assign phase_off    = {1'b0, phase_r} + (PHASE_W + 1)'(COIL_OFFSET);
  assign phase_b_next = (phase_off >= (PHASE_W + 1)'(PHASES)) ?
                        PHASE_W'(phase_off - (PHASE_W + 1)'(PHASES)) :
                        phase_off[PHASE_W-1:0];

  // One level read per cycle: coil A on the tick, coil B the cycle after.
  assign wv       = wave_lookup(cmd.do_tick ? phase_r : phase_b_r);
  assign level_rd = (wv.sel == 3'd7) ? '0 : level_r[wv.sel];

  always_comb begin
    if (quotient > DIV_W'(PERIOD_MAX)) begin
      raw_period = PERIOD_MAX;
    end else if (quotient < DIV_W'(PERIOD_MIN)) begin
      raw_period = PERIOD_MIN;
    end else begin
      raw_period = quotient[PERIOD_W-1:0];
    end
  end

  assign hist_old     = hist_r[slot_r];
  assign total        = sum_r - SUM_W'(hist_old) + SUM_W'(raw_period);
  assign avg_prod     = PROD_W'(PROD_W'(total) * PROD_W'(AVG_MUL));
  assign avg_new      = avg_prod[AVG_SH +: PERIOD_W];
  assign div_dividend = STEP_RATE_NUM;
  assign div_divisor  = gap_r;

  gsmd_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  assign sts.upd_go   = act && (pos_r != tgt_in_r);
  assign sts.div_done = div_done;

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      tgt_in_r <= in_tdata[POS_W-1:0];
      req_r    <= in_tdata[POS_W];
    end
    if (cmd.upd_check && sts.upd_go) begin
      gap_r <= fwd_target ? (tgt_in_r - pos_r) : (pos_r - tgt_in_r);
    end
    if (cmd.do_tick) begin
      phase_b_r <= phase_b_next;
    end
    if (cmd.load_out) begin
      out_data_r <= {2'b00, active_r, pos_r, timer_r,
                     {avg_r, RELOAD_SH'(0)}, stepped_r,
                     coil_b_neg_r, coil_b_mag_r, coil_a_neg_r, coil_a_mag_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        level_r[i] <= LEVEL_RESET[i];
      end
      reverse_r    <= 1'b0;
      pos_r        <= '0;
      target_r     <= '0;
      dir_r        <= DIR_NONE;
      phase_r      <= '0;
      timer_r      <= 1'b0;
      active_r     <= 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
      slot_r       <= '0;
      sum_r        <= '0;
      avg_r        <= '0;
      reversed_r   <= 1'b0;
      stepped_r    <= 1'b0;
      coil_a_mag_r <= '0;
      coil_a_neg_r <= 1'b0;
      coil_b_mag_r <= '0;
      coil_b_neg_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_LEVEL0, REG_LEVEL1, REG_LEVEL2, REG_LEVEL3,
          REG_LEVEL4, REG_LEVEL5, REG_LEVEL6: begin
            level_r[cfg_index] <= cfg_wdata;
          end
          REG_REVERSE: begin
            reverse_r <= cfg_wdata[0];
          end
        endcase
      end

      if (cmd.latch_in) begin
        stepped_r <= 1'b0;
      end

      if (cmd.do_tick && timer_r) begin
        if (at_target) begin
          timer_r <= 1'b0;
        end else begin
          stepped_r    <= 1'b1;
          coil_a_mag_r <= level_rd;
          coil_a_neg_r <= wv.neg;
          phase_r      <= phase_next;
          pos_r        <= step_fwd ? pos_r + 1'b1 : pos_r - 1'b1;
        end
      end

      if (cmd.coil_b && stepped_r) begin
        coil_b_mag_r <= level_rd;
        coil_b_neg_r <= wv.neg;
      end

      if (cmd.upd_check) begin
        target_r <= tgt_in_r;
        active_r <= sts.upd_go;
        if (sts.upd_go) begin
          reversed_r <= fwd_target ? (dir_r == DIR_BACK) : (dir_r == DIR_FWD);
          dir_r      <= fwd_target ? DIR_FWD : DIR_BACK;
        end
      end

      if (cmd.div_avg) begin
        avg_r <= avg_new;
      end

      if (cmd.commit) begin
        slot_r <= (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
        if (timer_r && reversed_r) begin
          // Reversal while running: stop and flush the history.
          timer_r <= 1'b0;
          for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_r[i] <= PERIOD_REFILL;
          end
          sum_r <= REFILL_SUM;
        end else begin
          timer_r        <= 1'b1;
          hist_r[slot_r] <= avg_r;
          sum_r          <= sum_r - SUM_W'(hist_old) + SUM_W'(avg_r);
        end
      end
    end
  end

  assign out_tdata = out_data_r;

  `GSMD_ASSERT_HOLDS(a_phase_range, phase_r < PHASE_W'(PHASES), "wave phase out of range")
  `GSMD_ASSERT_NEXT(a_reverse_stops, cmd.commit && timer_r && reversed_r, !timer_r && sum_r == REFILL_SUM, "reversal did not stop timer")
  `GSMD_ASSERT_NEXT(a_tick_moves, cmd.do_tick && timer_r && !at_target, stepped_r && pos_r != $past(pos_r), "tick did not step")

endmodule

FILE: rtl/gsmd_ctrl.sv
// Controller: sequences ticks and control updates, owns the input
// ready and the result valid. Depends on gsmd_pkg.
`timescale 1ns / 1ps

`include "gauge_stepper_microstep_driver_unit_defines.svh"

module gsmd_ctrl
  import gsmd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic in_op,
  output logic out_tvalid,
  input  logic out_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK,
    S_TICK_B,
    S_UPD,
    S_RAW_START,
    S_RAW_WAIT,
    S_AVG,
    S_COMMIT,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_tready = state_r == S_IDLE;
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = (op_t'(in_op) == OP_TICK) ? S_TICK : S_UPD;
        end
      end
      S_TICK: begin
        cmd.do_tick = 1'b1;
        state_nxt   = S_TICK_B;
      end
      S_TICK_B: begin
        cmd.coil_b = 1'b1;
        state_nxt  = S_OUT;
      end
      S_UPD: begin
        cmd.upd_check = 1'b1;
        state_nxt     = sts.upd_go ? S_RAW_START : S_OUT;
      end
      S_RAW_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_RAW_WAIT;
      end
      S_RAW_WAIT: begin
        if (sts.div_done) begin
          state_nxt = S_AVG;
        end
      end
      S_AVG: begin
        // Capture the history average.
        cmd.div_avg = 1'b1;
        state_nxt   = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        // Hold until the result register is free.
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `GSMD_ASSERT_IMPLIES(a_load_free, cmd.load_out, slot_free, "result overwritten before transfer")
  `GSMD_ASSERT_NEXT(a_accept_busy, in_tvalid && in_tready, !in_tready && !cmd.load_out, "accept did not start work")
  `GSMD_ASSERT_IMPLIES(a_div_done_wait, sts.div_done, state_r == S_RAW_WAIT, "divider done outside a wait state")

endmodule

FILE: rtl/gauge_stepper_microstep_driver_unit.sv
// Top level of the gauge stepper microstep driver.
// Joins gsmd_ctrl and gsmd_datapath; depends on gsmd_pkg.
//
//   channel  direction  tdata / tuser
//   in_*     input      tdata: target_position, move_request; tuser: operation
//   out_*    output     tdata: coil fields, step period, timer, position, move
//   cfg_*    input      write enable, register index, write data
//
// A timer tick passes the tick, second-coil and output states; a control
// update with an active move runs one pass of the 23-step serial divider
// on the gap, and the history average is a reciprocal multiply.
// An update that leaves the move idle skips the divider.
// Reset is synchronous and restores the level registers to the sine wave.
// A stalled result holds in its register; the next input transfer is taken
// meanwhile and its result waits until the register frees.
`timescale 1ns / 1ps

module gauge_stepper_microstep_driver_unit
  import gsmd_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [LEVEL_W-1:0]    cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [14:0] target_position, [15] move_request
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] operation
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [9:0] coil_a_duty, [10] coil_a_reversed, [20:11] coil_b_duty,
  // [21] coil_b_reversed, [22] coil_update, [44:23] step_period,
  // [45] timer_running, [60:46] position, [61] move_active, [63:62] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  cmd_t cmd;
  sts_t sts;

  gsmd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  gsmd_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

FILE: tb/tb_top.sv
// Self-checking bench for gauge_stepper_microstep_driver_unit: a shadow of the
// driver state predicts every result word. Depends on gsmd_pkg and the unit.
`timescale 1ns / 1ps

module tb_top
  import gsmd_pkg::*;
();

  localparam int DEPTH      = HISTORY_DEPTH_DEF;
  localparam int LIMIT      = 500000;
  localparam int PHASES_RUN = 6;
  localparam int PHASE_LEN  = 200;

  typedef struct packed {
    logic [1:0]          spare;
    logic                move_active;
    logic [POS_W-1:0]    position;
    logic                timer_running;
    logic [RELOAD_W-1:0] step_period;
    logic                coil_update;
    logic                b_neg;
    logic [LEVEL_W-1:0]  b_duty;
    logic                a_neg;
    logic [LEVEL_W-1:0]  a_duty;
  } drive_word_t;

  class gauge_tracker;
    int unsigned lvl [NUM_LEVELS];
    int unsigned reverse;
    int unsigned position, target, phase, timer_on, active;
    dir_t        heading;
    int unsigned hist [DEPTH];
    int unsigned slot, reload;
    int unsigned a_duty, a_neg, b_duty, b_neg;
    drive_word_t coil_forecast [$];
    int          mismatches;

    function new();
      foreach (lvl[i]) lvl[i] = LEVEL_RESET[i];
      reverse = 0;
      position = 0; target = 0; phase = 0; timer_on = 0; active = 0;
      heading = DIR_NONE;
      foreach (hist[i]) hist[i] = 0;
      slot = 0; reload = 0;
      a_duty = 0; a_neg = 0; b_duty = 0; b_neg = 0;
      mismatches = 0;
    endfunction

    function void write_reg(reg_idx_t idx, int unsigned value);
      if (idx == REG_REVERSE) reverse = value & 1;
      else lvl[idx] = value & ((1 << LEVEL_W) - 1);
    endfunction

    // Magnitude and sign of the wave at a phase, folded from the 90-degree levels.
    function void wave_at(int unsigned idx, output int unsigned mag, output int unsigned neg);
      idx = idx % PHASES;
      if (idx <= 6) begin
        mag = lvl[idx]; neg = 0;
      end else if (idx <= 12) begin
        mag = lvl[12 - idx]; neg = 0;
      end else if (idx <= 18) begin
        mag = lvl[idx - 12]; neg = 1;
      end else begin
        mag = lvl[24 - idx]; neg = 1;
      end
    endfunction

    function void retarget(int unsigned tgt, bit req);
      int unsigned gap, raw, total, avg;
      bit flipped;
      flipped = 0;
      target = tgt;
      if (req) active = 1;
      if (!active) return;
      if (position == target) begin
        active = 0;
        return;
      end
      if (target > position) begin
        gap = target - position;
        flipped = (heading == DIR_BACK);
        heading = DIR_FWD;
      end else begin
        gap = position - target;
        flipped = (heading == DIR_FWD);
        heading = DIR_BACK;
      end
      raw = 500000 / gap;
      if (raw > PERIOD_MAX) raw = PERIOD_MAX;
      if (raw < PERIOD_MIN) raw = PERIOD_MIN;
      total = 0;
      foreach (hist[i]) total += hist[i];
      total = total - hist[slot] + raw;
      avg = total / DEPTH;
      hist[slot] = avg & 16'hFFFF;
      slot = (slot + 1) % DEPTH;
      reload = avg << RELOAD_SH;
      if (timer_on == 0) begin
        timer_on = 1;
      end else if (flipped) begin
        timer_on = 0;
        foreach (hist[i]) hist[i] = PERIOD_REFILL;
      end
    endfunction

    function void microstep(bit fwd);
      bit up;
      up = fwd ? (reverse == 0) : (reverse != 0);
      wave_at(phase, a_duty, a_neg);
      wave_at(phase + COIL_OFFSET, b_duty, b_neg);
      if (up) phase = (phase >= PHASES - 1) ? 0 : phase + 1;
      else phase = (phase == 0) ? PHASES - 1 : phase - 1;
      position = (fwd ? position + 1 : position - 1) & ((1 << POS_W) - 1);
    endfunction

    function void note_transfer(op_t op, logic [POS_W-1:0] tgt, logic req);
      drive_word_t w;
      bit stepped;
      stepped = 0;
      if (op == OP_UPDATE) begin
        retarget(tgt, req);
      end else if (timer_on) begin
        if (position == target) begin
          timer_on = 0;
        end else begin
          microstep(heading == DIR_FWD);
          stepped = 1;
        end
      end
      w.spare         = '0;
      w.move_active   = active[0];
      w.position      = position[POS_W-1:0];
      w.timer_running = timer_on[0];
      w.step_period   = reload[RELOAD_W-1:0];
      w.coil_update   = stepped;
      w.b_neg         = b_neg[0];
      w.b_duty        = b_duty[LEVEL_W-1:0];
      w.a_neg         = a_neg[0];
      w.a_duty        = a_duty[LEVEL_W-1:0];
      coil_forecast.push_back(w);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] word);
      drive_word_t got, want;
      string bad;
      got = word;
      if (coil_forecast.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", word);
        return;
      end
      want = coil_forecast.pop_front();
      bad = "";
      if (got.a_duty !== want.a_duty) bad = {bad, " coil_a_duty"};
      if (got.a_neg !== want.a_neg) bad = {bad, " coil_a_reversed"};
      if (got.b_duty !== want.b_duty) bad = {bad, " coil_b_duty"};
      if (got.b_neg !== want.b_neg) bad = {bad, " coil_b_reversed"};
      if (got.coil_update !== want.coil_update) bad = {bad, " coil_update"};
      if (got.step_period !== want.step_period) bad = {bad, " step_period"};
      if (got.timer_running !== want.timer_running) bad = {bad, " timer_running"};
      if (got.position !== want.position) bad = {bad, " position"};
      if (got.move_active !== want.move_active) bad = {bad, " move_active"};
      if (got.spare !== want.spare) bad = {bad, " padding"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %h got %h, fields:%s", want, got, bad);
      end
    endfunction

    function int pending();
      return coil_forecast.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [LEVEL_W-1:0]    cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  gauge_tracker tracker = new();
  bit           idle_on = 1'b0;
  int           stall_left = 0;
  int           cycle_count = 0;

  gauge_stepper_microstep_driver_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: check each transfer, stall the receiver in random bursts.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata);
      if (stall_left > 0) stall_left--;
      else if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 14);
      out_tready <= (stall_left == 0);
    end
  end

  // Hold the item until the transfer; tvalid stays high for back-to-back items.
  task automatic push_item(op_t op, logic [POS_W-1:0] tgt, logic req);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {req, tgt};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    tracker.note_transfer(op, tgt, req);
  endtask

  task automatic write_reg(reg_idx_t idx, int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[LEVEL_W-1:0];
    @(posedge clk);
    tracker.write_reg(idx, value);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_levels(int setting);
    int unsigned v;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      case (setting)
        0: v = 1023;
        1: v = 0;
        2: v = LEVEL_RESET[i];
        default: v = $urandom_range(0, 1023);
      endcase
      write_reg(reg_idx_t'(REG_LEVEL0 + i), v);
    end
    case (setting)
      0: v = 1;
      1: v = 0;
      2: v = 1023;
      default: v = $urandom_range(0, 1023);
    endcase
    write_reg(REG_REVERSE, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(int n_items, bit allow_idle);
    int sent;
    int kind;
    int delta;
    int ticks;
    logic [POS_W-1:0] tgt;
    sent = 0;
    idle_on = allow_idle;
    while (sent < n_items) begin
      if (allow_idle && $urandom_range(0, 20) == 0) idle_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        // well-formed move: retarget (mostly within 40), tick toward it; near moves get up to three extra ticks
        delta = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 32767) : $urandom_range(1, 40);
        tgt = $urandom_range(0, 1) ? POS_W'(tracker.position + delta)
                                   : POS_W'(tracker.position - delta);
        push_item(OP_UPDATE, tgt, 1'b1);
        sent++;
        ticks = ((delta > 40) ? $urandom_range(1, 30) : delta) + $urandom_range(0, 3);
        repeat (ticks) begin
          if ($urandom_range(0, 15) == 0) begin
            push_item(OP_UPDATE, POS_W'(tracker.position + $urandom_range(0, 10) - 5),
                      1'($urandom_range(0, 1)));
            sent++;
          end
          push_item(OP_TICK, POS_W'($urandom), 1'($urandom_range(0, 1)));
          sent++;
        end
      end else if (kind < 8) begin
        tgt = $urandom_range(0, 1) ? POS_W'(tracker.position) : POS_W'($urandom);
        push_item(OP_UPDATE, tgt, 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        push_item(op_t'($urandom_range(0, 1)), POS_W'($urandom), 1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: reset levels, no idling.
    push_item(OP_TICK, 15'h7FFF, 1'b1);        // timer off: ignored
    push_item(OP_UPDATE, 15'd0, 1'b0);         // inactive: store target only
    push_item(OP_UPDATE, 15'd0, 1'b1);         // already at target
    push_item(OP_UPDATE, 15'd4, 1'b1);         // start forward
    repeat (4) push_item(OP_TICK, 15'd0, 1'b0);
    push_item(OP_TICK, 15'd0, 1'b0);           // at target: timer stops
    push_item(OP_UPDATE, 15'd2, 1'b1);         // reversed but timer off: start
    push_item(OP_TICK, 15'd0, 1'b0);
    push_item(OP_UPDATE, 15'd7, 1'b1);         // reversal while running: stop, refill
    push_item(OP_UPDATE, 15'd1, 1'b1);
    push_item(OP_TICK, 15'd0, 1'b0);
    push_item(OP_UPDATE, 15'd2, 1'b0);         // clears the move, timer keeps running
    push_item(OP_UPDATE, 15'h7FFF, 1'b0);
    repeat (3) push_item(OP_TICK, 15'd0, 1'b0); // backward through zero and phase zero
    push_item(OP_TICK, 15'd0, 1'b0);
    push_item(OP_UPDATE, 15'd0, 1'b1);         // widest gap: clamp low
    push_item(OP_UPDATE, 15'h7FFE, 1'b1);      // gap of one: clamp high
    push_item(OP_TICK, 15'h7FFF, 1'b1);
    push_item(OP_UPDATE, 15'h7FFF, 1'b1);
    drain();

    for (int p = 0; p < PHASES_RUN; p++) begin
      load_levels(p);
      random_phase(PHASE_LEN, p != PHASES_RUN - 1);
      drain();
    end

    idle_on = 1'b0;
    repeat (64) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
